@@ design/pwp_pkg.sv @@
// Shared constants, codes and types for the two-lane priority write pacer.
package pwp_pkg;

  localparam int HIGH_DEPTH = 64;
  localparam int LOW_DEPTH  = 256;
  localparam int TAG_BITS   = 32;

  localparam int HIGH_AW    = $clog2(HIGH_DEPTH);
  localparam int LOW_AW     = $clog2(LOW_DEPTH);
  localparam int HIGH_CW    = $clog2(HIGH_DEPTH + 1);
  localparam int LOW_CW     = $clog2(LOW_DEPTH + 1);
  localparam int TICK_W     = 16;

  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  // command codes
  localparam logic [1:0] CMD_ENQ    = 2'd0;
  localparam logic [1:0] CMD_SETTLE = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_LINK  = 2'd0;
  localparam logic [1:0] REG_LONG  = 2'd1;
  localparam logic [1:0] REG_SHORT = 2'd2;
  localparam logic [1:0] REG_FAST  = 2'd3;

  localparam logic [TICK_W-1:0] LONG_TICKS_RST  = TICK_W'(1500);
  localparam logic [TICK_W-1:0] SHORT_TICKS_RST = TICK_W'(250);

  typedef struct packed {
    logic                resp;
    logic [TAG_BITS-1:0] tag;
  } lane_entry_t;

  localparam int ENTRY_W = $bits(lane_entry_t);

endpackage

@@ design/pwp_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data.
module pwp_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ design/two_lane_priority_write_pacer.sv @@
// Top level: two-lane strict-priority write pacer with watchdog.
//
//  channel   | handshake                        | payload
//  ----------+----------------------------------+-----------------------------------------
//  command   | start, busy (busy is always low) | command, frame_tag, is_live, with_response
//  result    | done strobe, one cycle, no stall | issue_*, dropped_oldest, rejected,
//            |                                  | timed_out, busy_res, high_count, low_count
//  config    | APB write/read, pready always 1  | paddr[3:2] selects register, pwdata
//
// One beat is taken every cycle. Its result shows on done after an input register, then
// the lane/watchdog update into the result register.
// Lane heads come from the lane RAMs' registered read port, refreshed every cycle at
// the next head address, with a bypass for an entry written the cycle before.
// rst clears occupancy, the outstanding slot, the watchdog and the registers to their
// reset values; lane contents are left as they are. No result is ever held back.
module two_lane_priority_write_pacer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   command,
  input  logic [pwp_pkg::TAG_BITS-1:0] frame_tag,
  input  logic                         is_live,
  input  logic                         with_response,
  output logic                         done,
  output logic                         issue_valid,
  output logic [pwp_pkg::TAG_BITS-1:0] issue_tag,
  output logic                         issue_acknowledged,
  output logic                         dropped_oldest,
  output logic                         rejected,
  output logic                         timed_out,
  output logic                         busy_res,
  output logic [pwp_pkg::HIGH_CW-1:0]  high_count,
  output logic [pwp_pkg::LOW_CW-1:0]   low_count,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pwp_pkg::APB_AW-1:0]   paddr,
  input  logic [pwp_pkg::APB_DW-1:0]   pwdata,
  output logic [pwp_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import pwp_pkg::*;

  // configuration
  logic              link_ready;
  logic [TICK_W-1:0] long_ticks;
  logic [TICK_W-1:0] short_ticks;
  logic              fast_mode;
  logic              cfg_we;

  // input register
  logic                in_valid;
  logic [1:0]          cmd_q;
  logic [TAG_BITS-1:0] tag_q;
  logic                live_q;
  logic                resp_q;

  // lane and slot state
  logic [HIGH_AW-1:0] high_head, high_head_next, high_tail, high_tail_next;
  logic [LOW_AW-1:0]  low_head, low_head_next, low_tail, low_tail_next;
  logic [HIGH_CW-1:0] high_cnt, high_cnt_next;
  logic [LOW_CW-1:0]  low_cnt, low_cnt_next;
  logic               outstanding, outstanding_next;
  logic [TICK_W-1:0]  wd, wd_next;

  // lane RAM ports
  logic               high_we, low_we;
  lane_entry_t        in_entry;
  lane_entry_t        high_rdata, low_rdata;
  lane_entry_t        high_wdata_q, low_wdata_q;
  logic               high_byp, low_byp;
  lane_entry_t        high_head_val, low_head_val;

  // step results
  logic               do_pump;
  logic               r_issue, r_ack, r_drop, r_rej, r_to;
  lane_entry_t        r_entry;

  assign busy     = 1'b0;
  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite;
  assign in_entry = '{resp: resp_q, tag: tag_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      link_ready  <= 1'b0;
      long_ticks  <= LONG_TICKS_RST;
      short_ticks <= SHORT_TICKS_RST;
      fast_mode   <= 1'b0;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_LINK:  link_ready  <= pwdata[0];
        REG_LONG:  long_ticks  <= pwdata[TICK_W-1:0];
        REG_SHORT: short_ticks <= pwdata[TICK_W-1:0];
        REG_FAST:  fast_mode   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LINK:  prdata = APB_DW'(link_ready);
      REG_LONG:  prdata = APB_DW'(long_ticks);
      REG_SHORT: prdata = APB_DW'(short_ticks);
      REG_FAST:  prdata = APB_DW'(fast_mode);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q  <= command;
    tag_q  <= frame_tag;
    live_q <= is_live;
    resp_q <= with_response;
  end

  // head value: last registered read, or the entry written there last cycle
  assign high_head_val = high_byp ? high_wdata_q : high_rdata;
  assign low_head_val  = low_byp  ? low_wdata_q  : low_rdata;

  always_comb begin
    high_head_next   = high_head;
    high_tail_next   = high_tail;
    high_cnt_next    = high_cnt;
    low_head_next    = low_head;
    low_tail_next    = low_tail;
    low_cnt_next     = low_cnt;
    outstanding_next = outstanding;
    wd_next          = wd;
    high_we          = 1'b0;
    low_we           = 1'b0;
    do_pump          = 1'b0;
    r_issue          = 1'b0;
    r_ack            = 1'b0;
    r_drop           = 1'b0;
    r_rej            = 1'b0;
    r_to             = 1'b0;
    r_entry          = in_entry;

    if (in_valid) begin
      if (!link_ready) begin
        high_head_next   = '0;
        high_tail_next   = '0;
        high_cnt_next    = '0;
        low_head_next    = '0;
        low_tail_next    = '0;
        low_cnt_next     = '0;
        outstanding_next = 1'b0;
        wd_next          = '0;
        r_rej            = (cmd_q == CMD_ENQ);
      end else begin
        case (cmd_q)
          CMD_ENQ: begin
            if (!outstanding) begin
              // slot free means both lanes are empty: send the beat straight out
              r_issue          = 1'b1;
              r_entry          = in_entry;
              r_ack            = !fast_mode || resp_q;
              outstanding_next = 1'b1;
              wd_next          = r_ack ? long_ticks : short_ticks;
            end else if (live_q) begin
              if (high_cnt == HIGH_CW'(HIGH_DEPTH)) begin
                r_rej = 1'b1;
              end else begin
                high_we        = 1'b1;
                high_tail_next = (high_tail == HIGH_AW'(HIGH_DEPTH - 1)) ? '0
                                 : high_tail + 1'b1;
                high_cnt_next  = high_cnt + 1'b1;
              end
            end else begin
              low_we        = 1'b1;
              low_tail_next = (low_tail == LOW_AW'(LOW_DEPTH - 1)) ? '0 : low_tail + 1'b1;
              if (low_cnt == LOW_CW'(LOW_DEPTH)) begin
                // drop the oldest to make room
                r_drop        = 1'b1;
                low_head_next = (low_head == LOW_AW'(LOW_DEPTH - 1)) ? '0 : low_head + 1'b1;
              end else begin
                low_cnt_next = low_cnt + 1'b1;
              end
            end
          end
          CMD_SETTLE: begin
            outstanding_next = 1'b0;
            wd_next          = '0;
            do_pump          = 1'b1;
          end
          CMD_TICK: begin
            if (outstanding) begin
              if (wd <= TICK_W'(1)) begin
                r_to             = 1'b1;
                outstanding_next = 1'b0;
                wd_next          = '0;
                do_pump          = 1'b1;
              end else begin
                wd_next = wd - 1'b1;
              end
            end
          end
          CMD_CLEAR: begin
            high_head_next   = '0;
            high_tail_next   = '0;
            high_cnt_next    = '0;
            low_head_next    = '0;
            low_tail_next    = '0;
            low_cnt_next     = '0;
            outstanding_next = 1'b0;
            wd_next          = '0;
          end
          default: ;
        endcase

        // issue from the high lane first, then the low lane
        if (do_pump) begin
          if (high_cnt != '0) begin
            r_issue        = 1'b1;
            r_entry        = high_head_val;
            high_head_next = (high_head == HIGH_AW'(HIGH_DEPTH - 1)) ? '0
                             : high_head + 1'b1;
            high_cnt_next  = high_cnt - 1'b1;
          end else if (low_cnt != '0) begin
            r_issue       = 1'b1;
            r_entry       = low_head_val;
            low_head_next = (low_head == LOW_AW'(LOW_DEPTH - 1)) ? '0 : low_head + 1'b1;
            low_cnt_next  = low_cnt - 1'b1;
          end
          if (r_issue) begin
            r_ack            = !fast_mode || r_entry.resp;
            outstanding_next = 1'b1;
            wd_next          = r_ack ? long_ticks : short_ticks;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_head   <= '0;
      high_tail   <= '0;
      high_cnt    <= '0;
      low_head    <= '0;
      low_tail    <= '0;
      low_cnt     <= '0;
      outstanding <= 1'b0;
      wd          <= '0;
      high_byp    <= 1'b0;
      low_byp     <= 1'b0;
      done        <= 1'b0;
    end else begin
      high_head   <= high_head_next;
      high_tail   <= high_tail_next;
      high_cnt    <= high_cnt_next;
      low_head    <= low_head_next;
      low_tail    <= low_tail_next;
      low_cnt     <= low_cnt_next;
      outstanding <= outstanding_next;
      wd          <= wd_next;
      high_byp    <= high_we && (high_tail == high_head_next);
      low_byp     <= low_we && (low_tail == low_head_next);
      done        <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    high_wdata_q       <= in_entry;
    low_wdata_q        <= in_entry;
    issue_valid        <= r_issue;
    issue_tag          <= r_issue ? r_entry.tag : '0;
    issue_acknowledged <= r_ack;
    dropped_oldest     <= r_drop;
    rejected           <= r_rej;
    timed_out          <= r_to;
    busy_res           <= outstanding_next;
    high_count         <= high_cnt_next;
    low_count          <= low_cnt_next;
  end

  pwp_ram #(
    .DEPTH (HIGH_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_high_ram (
    .clk   (clk),
    .we    (high_we),
    .waddr (high_tail),
    .wdata (in_entry),
    .raddr (high_head_next),
    .rdata (high_rdata)
  );

  pwp_ram #(
    .DEPTH (LOW_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_low_ram (
    .clk   (clk),
    .we    (low_we),
    .waddr (low_tail),
    .wdata (in_entry),
    .raddr (low_head_next),
    .rdata (low_rdata)
  );

endmodule

@@ design/pwp_checker.sv @@
// Port-level checker for the write pacer, bound to the top level.
module pwp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic                         issue_valid,
  input logic [pwp_pkg::TAG_BITS-1:0] issue_tag,
  input logic                         issue_acknowledged,
  input logic                         dropped_oldest,
  input logic                         rejected,
  input logic                         timed_out,
  input logic                         busy_res,
  input logic [pwp_pkg::HIGH_CW-1:0]  high_count,
  input logic [pwp_pkg::LOW_CW-1:0]   low_count
);
  import pwp_pkg::*;

  // every accepted beat yields exactly one result, through the input and result registers
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(rst, 2)) |-> (done == $past(start && !busy, 2)))
    else $error("result strobe does not match accepted beats");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    (done && !issue_valid) |-> (issue_tag == '0 && !issue_acknowledged))
    else $error("issue fields set without an issue");

  a_issue_busy: assert property (@(posedge clk) disable iff (rst)
    (done && issue_valid) |-> busy_res)
    else $error("issued frame but slot not held");

  // a free slot means nothing is waiting
  a_free_empty: assert property (@(posedge clk) disable iff (rst)
    (done && !busy_res) |-> (high_count == '0 && low_count == '0))
    else $error("frames waiting while slot is free");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (done && (dropped_oldest || rejected || timed_out && !busy_res)) |->
      (!issue_valid && (!dropped_oldest || low_count == LOW_CW'(LOW_DEPTH))))
    else $error("drop or reject alongside an issue, or drop below full");

endmodule

bind two_lane_priority_write_pacer pwp_checker u_pwp_checker (.*);

@@ sim/tb_top.sv @@
// Self-checking testbench for the two-lane priority write pacer: directed and random beats.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pwp_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PRINT_LIMIT = 40;

  typedef struct {
    bit                issued;
    bit [TAG_BITS-1:0] tag;
    bit                acked;
    bit                dropped;
    bit                refused;
    bit                expired;
    bit                outstanding;
    bit [HIGH_CW-1:0]  high_n;
    bit [LOW_CW-1:0]   low_n;
  } pacer_result_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic [1:0]          command;
  logic [TAG_BITS-1:0] frame_tag;
  logic                is_live;
  logic                with_response;
  logic                done;
  logic                issue_valid;
  logic [TAG_BITS-1:0] issue_tag;
  logic                issue_acknowledged;
  logic                dropped_oldest;
  logic                rejected;
  logic                timed_out;
  logic                busy_res;
  logic [HIGH_CW-1:0]  high_count;
  logic [LOW_CW-1:0]   low_count;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // predictor state
  lane_entry_t         high_waiting[$];
  lane_entry_t         low_waiting[$];
  bit                  slot_taken;
  bit [TICK_W-1:0]     watchdog_left;
  bit                  link_up;
  bit [TICK_W-1:0]     long_ticks = LONG_TICKS_RST;
  bit [TICK_W-1:0]     short_ticks = SHORT_TICKS_RST;
  bit                  fast;

  pacer_result_t       pending_results[$];
  pacer_result_t       want;

  int errors = 0;
  int cycle_count = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int issues_seen = 0;
  int timeouts_seen = 0;
  int refusals_seen = 0;
  int drops_seen = 0;
  int config_phases = 0;
  bit no_idle = 1'b0;

  two_lane_priority_write_pacer uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .frame_tag(frame_tag), .is_live(is_live), .with_response(with_response),
    .done(done), .issue_valid(issue_valid), .issue_tag(issue_tag),
    .issue_acknowledged(issue_acknowledged), .dropped_oldest(dropped_oldest),
    .rejected(rejected), .timed_out(timed_out), .busy_res(busy_res),
    .high_count(high_count), .low_count(low_count), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] expected);
    errors++;
    if (errors <= PRINT_LIMIT)
      $display("MISMATCH cycle %0d: %s got %0h expected %0h", cycle_count, what, got, expected);
  endtask

  function automatic void flush_lanes();
    high_waiting.delete();
    low_waiting.delete();
    slot_taken = 1'b0;
    watchdog_left = '0;
  endfunction

  // Take the next frame into the free slot, high lane first, and arm the watchdog.
  function automatic void issue_next(inout pacer_result_t r);
    lane_entry_t e;
    bit acked;
    if (slot_taken) return;
    if (high_waiting.size() > 0) begin
      e = high_waiting[0];
      high_waiting.delete(0);
    end else if (low_waiting.size() > 0) begin
      e = low_waiting[0];
      low_waiting.delete(0);
    end else begin
      return;
    end
    acked = !fast || e.resp;
    slot_taken = 1'b1;
    watchdog_left = acked ? long_ticks : short_ticks;
    r.issued = 1'b1;
    r.tag = e.tag;
    r.acked = acked;
  endfunction

  function automatic pacer_result_t next_pacer_result(input logic [1:0] cmd,
                                                     input logic [TAG_BITS-1:0] tag,
                                                     input logic live, input logic resp);
    pacer_result_t r;
    lane_entry_t e;
    r = '{default: 0};
    e.resp = resp;
    e.tag = tag;
    if (!link_up) begin
      flush_lanes();
      if (cmd == CMD_ENQ) r.refused = 1'b1;
    end else begin
      case (cmd)
        CMD_ENQ: begin
          if (live) begin
            if (high_waiting.size() >= HIGH_DEPTH) r.refused = 1'b1;
            else high_waiting.push_back(e);
          end else begin
            if (low_waiting.size() >= LOW_DEPTH) begin
              low_waiting.delete(0);
              r.dropped = 1'b1;
            end
            low_waiting.push_back(e);
          end
          issue_next(r);
        end
        CMD_SETTLE: begin
          slot_taken = 1'b0;
          watchdog_left = '0;
          issue_next(r);
        end
        CMD_TICK: begin
          if (slot_taken) begin
            // a watchdog armed with zero expires like one armed with one
            if (watchdog_left <= 1) begin
              r.expired = 1'b1;
              slot_taken = 1'b0;
              watchdog_left = '0;
              issue_next(r);
            end else begin
              watchdog_left--;
            end
          end
        end
        default: flush_lanes();
      endcase
    end
    r.outstanding = slot_taken;
    r.high_n = HIGH_CW'(high_waiting.size());
    r.low_n = LOW_CW'(low_waiting.size());
    return r;
  endfunction

  task automatic send_beat(input logic [1:0] cmd, input logic [TAG_BITS-1:0] tag,
                           input logic live, input logic resp);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    frame_tag <= tag;
    is_live <= live;
    with_response <= resp;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(next_pacer_result(cmd, tag, live, resp));
    beats_sent++;
  endtask

  // Hold the sender until every expected result has come back.
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_xfer(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] rd;
    logic [31:0] stored;
    apb_xfer(1'b1, idx, value, rd);
    case (idx)
      REG_LINK: begin
        link_up = value[0];
        stored = 32'(value[0]);
      end
      REG_LONG: begin
        long_ticks = value[TICK_W-1:0];
        stored = 32'(value[TICK_W-1:0]);
      end
      REG_SHORT: begin
        short_ticks = value[TICK_W-1:0];
        stored = 32'(value[TICK_W-1:0]);
      end
      default: begin
        fast = value[0];
        stored = 32'(value[0]);
      end
    endcase
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== stored) report_mismatch("register readback", 64'(rd), 64'(stored));
  endtask

  task automatic set_config(input bit link, input int long_v, input int short_v,
                            input bit fast_v);
    wait_drained();
    write_reg(REG_LINK, 32'(link));
    write_reg(REG_LONG, 32'(long_v));
    write_reg(REG_SHORT, 32'(short_v));
    write_reg(REG_FAST, 32'(fast_v));
    config_phases++;
  endtask

  // Right after reset the link is down: everything is flushed, enqueues refused.
  task automatic test_link_down();
    send_beat(CMD_ENQ, '1, 1'b1, 1'b1);
    send_beat(CMD_ENQ, 32'h0000_0001, 1'b0, 1'b0);
    send_beat(CMD_SETTLE, '0, 1'b0, 1'b0);
    send_beat(CMD_TICK, '0, 1'b0, 1'b0);
    send_beat(CMD_CLEAR, '0, 1'b0, 1'b0);
  endtask

  task automatic test_directed_ops();
    set_config(1'b1, 3, 0, 1'b1);
    send_beat(CMD_ENQ, '0, 1'b0, 1'b0);               // unacked, zero-tick watchdog
    send_beat(CMD_TICK, '0, 1'b0, 1'b0);              // expire at once
    send_beat(CMD_TICK, '0, 1'b0, 1'b0);              // idle tick
    send_beat(CMD_SETTLE, '0, 1'b0, 1'b0);            // settle with nothing outstanding
    send_beat(CMD_ENQ, '1, 1'b1, 1'b1);
    send_beat(CMD_ENQ, 32'h5555_5555, 1'b0, 1'b1);
    send_beat(CMD_ENQ, 32'hAAAA_AAAA, 1'b1, 1'b0);
    repeat (3) send_beat(CMD_TICK, '0, 1'b0, 1'b0);   // live frame wins on expiry
    send_beat(CMD_SETTLE, '0, 1'b0, 1'b0);
    send_beat(CMD_SETTLE, '0, 1'b0, 1'b0);
    send_beat(CMD_ENQ, 32'h0F0F_0F0F, 1'b1, 1'b1);
    send_beat(CMD_ENQ, 32'hF0F0_F0F0, 1'b0, 1'b1);
    send_beat(CMD_ENQ, 32'h1234_5678, 1'b1, 1'b0);
    send_beat(CMD_CLEAR, '0, 1'b0, 1'b0);
    send_beat(CMD_ENQ, 32'h8000_0000, 1'b0, 1'b1);
    send_beat(CMD_TICK, '0, 1'b0, 1'b0);
    send_beat(CMD_SETTLE, '0, 1'b0, 1'b0);
  endtask

  task automatic test_high_lane_full();
    set_config(1'b1, 65535, 65535, 1'b0);
    send_beat(CMD_CLEAR, '0, 1'b0, 1'b0);
    // one goes out, HIGH_DEPTH wait, the rest are refused
    repeat (HIGH_DEPTH + 3) send_beat(CMD_ENQ, $urandom, 1'b1, 1'($urandom_range(0, 1)));
    repeat (2) send_beat(CMD_SETTLE, '0, 1'b0, 1'b0);
    send_beat(CMD_CLEAR, '0, 1'b0, 1'b0);
  endtask

  task automatic test_low_lane_full();
    set_config(1'b1, 65535, 1, 1'b1);
    repeat (LOW_DEPTH + 5) send_beat(CMD_ENQ, $urandom, 1'b0, 1'($urandom_range(0, 1)));
    repeat (3) send_beat(CMD_SETTLE, '0, 1'b0, 1'b0);
    // drop the link with frames waiting in the low lane and a write outstanding
    set_config(1'b0, 65535, 1, 1'b1);
    send_beat(CMD_TICK, '0, 1'b0, 1'b0);
    send_beat(CMD_ENQ, $urandom, 1'b0, 1'b1);
  endtask

  task automatic test_random_traffic(input int n, input int enq_pct, input int live_pct,
                                     input int settle_pct, input int clear_pct);
    int roll;
    logic [1:0] cmd;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < enq_pct) cmd = CMD_ENQ;
      else if (roll < enq_pct + settle_pct) cmd = CMD_SETTLE;
      else if (roll < enq_pct + settle_pct + clear_pct) cmd = CMD_CLEAR;
      else cmd = CMD_TICK;
      send_beat(cmd, $urandom, $urandom_range(0, 99) < live_pct,
                1'($urandom_range(0, 1)));
      if ($urandom_range(0, 299) == 0) wait_drained();
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(issue_tag), '0);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        results_seen++;
        if (want.issued) issues_seen++;
        if (want.expired) timeouts_seen++;
        if (want.refused) refusals_seen++;
        if (want.dropped) drops_seen++;
        if (issue_valid !== want.issued)
          report_mismatch("issue_valid", 64'(issue_valid), 64'(want.issued));
        if (issue_tag !== want.tag)
          report_mismatch("issue_tag", 64'(issue_tag), 64'(want.tag));
        if (issue_acknowledged !== want.acked)
          report_mismatch("issue_acknowledged", 64'(issue_acknowledged), 64'(want.acked));
        if (dropped_oldest !== want.dropped)
          report_mismatch("dropped_oldest", 64'(dropped_oldest), 64'(want.dropped));
        if (rejected !== want.refused)
          report_mismatch("rejected", 64'(rejected), 64'(want.refused));
        if (timed_out !== want.expired)
          report_mismatch("timed_out", 64'(timed_out), 64'(want.expired));
        if (busy_res !== want.outstanding)
          report_mismatch("busy_res", 64'(busy_res), 64'(want.outstanding));
        if (high_count !== want.high_n)
          report_mismatch("high_count", 64'(high_count), 64'(want.high_n));
        if (low_count !== want.low_n)
          report_mismatch("low_count", 64'(low_count), 64'(want.low_n));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    command = CMD_TICK;
    frame_tag = '0;
    is_live = 1'b0;
    with_response = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_link_down();
    test_directed_ops();
    test_high_lane_full();
    test_low_lane_full();

    set_config(1'b1, 5, 2, 1'b1);
    test_random_traffic(220, 40, 40, 15, 2);
    set_config(1'b1, 1, 0, 1'b0);
    test_random_traffic(150, 40, 50, 15, 2);
    set_config(1'b1, 65535, 65535, 1'b1);
    test_random_traffic(250, 75, 60, 8, 0);
    set_config(1'b1, 20, 7, 1'b1);
    test_random_traffic(220, 45, 50, 10, 2);
    set_config(1'b0, 9, 4, 1'b0);
    test_random_traffic(80, 50, 50, 15, 3);
    set_config(1'b1, 2, 1, 1'b1);
    test_random_traffic(220, 45, 30, 10, 2);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Checked %0d results from %0d beats over %0d register settings",
             results_seen, beats_sent, config_phases);
    $display("Frames issued %0d, watchdog expiries %0d, refusals %0d, low-lane drops %0d",
             issues_seen, timeouts_seen, refusals_seen, drops_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/pwp_pkg.sv
design/pwp_ram.sv
design/two_lane_priority_write_pacer.sv
design/pwp_checker.sv
sim/tb_top.sv
